FILE: hdl/gsfe_pkg.sv
// Package of shared types, constants and symbol tables for the genotype site filter encoder.
`timescale 1ns / 1ps

package gsfe_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int ALLELE_W    = COUNT_W + 1;
   localparam int CODE_W      = 4;
   localparam int VALUE_W     = 2;
   localparam int REASON_W    = 3;
   localparam int CFG_W       = 17;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = CFG_W + ALLELE_W;
   localparam int BIN_W       = 3;
   localparam int NUM_BINS    = 6;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CODE_W-1:0] CODE_A       = 4'd0;
   localparam logic [CODE_W-1:0] CODE_C       = 4'd1;
   localparam logic [CODE_W-1:0] CODE_G       = 4'd2;
   localparam logic [CODE_W-1:0] CODE_T       = 4'd3;
   localparam logic [CODE_W-1:0] CODE_M       = 4'd4;
   localparam logic [CODE_W-1:0] CODE_R       = 4'd5;
   localparam logic [CODE_W-1:0] CODE_W_HET   = 4'd6;
   localparam logic [CODE_W-1:0] CODE_S       = 4'd7;
   localparam logic [CODE_W-1:0] CODE_Y       = 4'd8;
   localparam logic [CODE_W-1:0] CODE_K       = 4'd9;
   localparam logic [CODE_W-1:0] CODE_N       = 4'd10;
   localparam logic [CODE_W-1:0] CODE_DASH    = 4'd11;
   localparam logic [CODE_W-1:0] CODE_LOWER_N = 4'd12;

   localparam logic [BIN_W-1:0] BIN_UNK  = 3'd0;
   localparam logic [BIN_W-1:0] BIN_A    = 3'd1;
   localparam logic [BIN_W-1:0] BIN_C    = 3'd2;
   localparam logic [BIN_W-1:0] BIN_G    = 3'd3;
   localparam logic [BIN_W-1:0] BIN_T    = 3'd4;
   localparam logic [BIN_W-1:0] BIN_MISS = 3'd5;
   localparam logic [BIN_W-1:0] BIN_NONE = 3'd7;

   localparam logic [VALUE_W-1:0] VAL_BEST    = 2'd0;
   localparam logic [VALUE_W-1:0] VAL_SECOND  = 2'd1;
   localparam logic [VALUE_W-1:0] VAL_MISSING = 2'd2;

   localparam logic [REASON_W-1:0] REASON_NONE     = 3'd0;
   localparam logic [REASON_W-1:0] REASON_MISSING  = 3'd1;
   localparam logic [REASON_W-1:0] REASON_HET      = 3'd2;
   localparam logic [REASON_W-1:0] REASON_MINOR    = 3'd3;
   localparam logic [REASON_W-1:0] REASON_KINDS    = 3'd4;
   localparam logic [REASON_W-1:0] REASON_OVERFLOW = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MISSING_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HET_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MINOR_FLOOR   = 2'd2;

   localparam logic [CFG_W-1:0] MISSING_LIMIT_RESET = 17'd16384;
   localparam logic [CFG_W-1:0] HET_LIMIT_RESET     = 17'd57672;
   localparam logic [CFG_W-1:0] MINOR_FLOOR_RESET   = 17'd328;

   typedef enum logic [1:0] {
      CHK_MISS  = 2'd0,
      CHK_HET   = 2'd1,
      CHK_MINOR = 2'd2
   } chk_type;

   typedef struct packed {
      logic [CFG_W-1:0] missing_limit;
      logic [CFG_W-1:0] het_limit;
      logic [CFG_W-1:0] minor_floor;
   } cfg_type;

   typedef struct packed {
      logic                accept;
      logic                scan_init;
      logic                scan_step;
      chk_type             chk;
      logic                emit_start;
      logic                emit_put;
      logic                reject_put;
      logic                clear;
      logic [REASON_W-1:0] reason;
   } cmd_type;

   typedef struct packed {
      logic overflow;
      logic scan_done;
      logic check_fail;
      logic kinds_bad;
      logic out_free;
      logic emit_last;
   } status_type;

   // Symbol bin of the first allele of a genotype code.
   function automatic logic [BIN_W-1:0] sym_a(input logic [CODE_W-1:0] code);
      logic [BIN_W-1:0] bin;
      unique case (code) inside
         CODE_A, CODE_M, CODE_R, CODE_W_HET: bin = BIN_A;
         CODE_C, CODE_S, CODE_Y:             bin = BIN_C;
         CODE_G, CODE_K:                     bin = BIN_G;
         CODE_T:                             bin = BIN_T;
         CODE_N, CODE_DASH:                  bin = BIN_MISS;
         default:                            bin = BIN_UNK;
      endcase
      return bin;
   endfunction

   // Symbol bin of the second allele of a genotype code.
   function automatic logic [BIN_W-1:0] sym_b(input logic [CODE_W-1:0] code);
      logic [BIN_W-1:0] bin;
      unique case (code) inside
         CODE_A:                             bin = BIN_A;
         CODE_C, CODE_M:                     bin = BIN_C;
         CODE_G, CODE_R, CODE_S:             bin = BIN_G;
         CODE_T, CODE_W_HET, CODE_Y, CODE_K: bin = BIN_T;
         CODE_N, CODE_DASH:                  bin = BIN_MISS;
         default:                            bin = BIN_UNK;
      endcase
      return bin;
   endfunction

endpackage

FILE: hdl/gsfe_req_if.sv
// Request channel interface carrying one genotype token.
`timescale 1ns / 1ps

interface gsfe_req_if;
   import gsfe_pkg::*;

   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   genotype_code;
   logic                last_sample;

   modport source (output valid, output genotype_code, output last_sample, input ready);
   modport sink (input valid, input genotype_code, input last_sample, output ready);
endinterface

FILE: hdl/gsfe_rsp_if.sv
// Result channel interface carrying one encoded sample or site reject.
`timescale 1ns / 1ps

interface gsfe_rsp_if;
   import gsfe_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  first_value;
   logic [VALUE_W-1:0]  second_value;
   logic                site_pass;
   logic [REASON_W-1:0] reject_reason;
   logic                last_result;

   modport source (output valid, output first_value, output second_value, output site_pass,
                   output reject_reason, output last_result, input ready);
   modport sink (input valid, input first_value, input second_value, input site_pass,
                 input reject_reason, input last_result, output ready);
endinterface

FILE: hdl/gsfe_csr_if.sv
// Configuration write channel interface.
`timescale 1ns / 1ps

interface gsfe_csr_if;
   import gsfe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/gsfe_regs.sv
// Filter threshold registers written over the configuration channel.
`timescale 1ns / 1ps

module gsfe_regs (
   input  logic              clock,
   input  logic              reset,
   gsfe_csr_if.sink          csr_if,
   output gsfe_pkg::cfg_type cfg
);
   import gsfe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_MISSING_LIMIT: cfg_in.missing_limit = csr_if.data;
            CSR_HET_LIMIT:     cfg_in.het_limit = csr_if.data;
            CSR_MINOR_FLOOR:   cfg_in.minor_floor = csr_if.data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.missing_limit <= MISSING_LIMIT_RESET;
         cfg_ff.het_limit <= HET_LIMIT_RESET;
         cfg_ff.minor_floor <= MINOR_FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/gsfe_ctrl.sv
// Controller state machine sequencing collection, allele scan, filters and emission.
`timescale 1ns / 1ps

module gsfe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  gsfe_pkg::status_type status,
   output gsfe_pkg::cmd_type    cmd
);
   import gsfe_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_SCAN    = 8'b00000010,
      S_MISS    = 8'b00000100,
      S_HET     = 8'b00001000,
      S_MINOR   = 8'b00010000,
      S_REJECT  = 8'b00100000,
      S_EMIT_RD = 8'b01000000,
      S_EMIT    = 8'b10000000
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [REASON_W-1:0] reason_ff;
   logic [REASON_W-1:0] reason_in;

   always_comb begin
      state_in = state_ff;
      reason_in = reason_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.chk = CHK_MISS;
      cmd.reason = reason_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_last) begin
                  cmd.scan_init = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               if (status.overflow) begin
                  reason_in = REASON_OVERFLOW;
                  state_in = S_REJECT;
               end else begin
                  state_in = S_MISS;
               end
            end
         end
         S_MISS: begin
            cmd.chk = CHK_MISS;
            if (status.check_fail) begin
               reason_in = REASON_MISSING;
               state_in = S_REJECT;
            end else begin
               state_in = S_HET;
            end
         end
         S_HET: begin
            cmd.chk = CHK_HET;
            if (status.check_fail) begin
               reason_in = REASON_HET;
               state_in = S_REJECT;
            end else begin
               state_in = S_MINOR;
            end
         end
         S_MINOR: begin
            cmd.chk = CHK_MINOR;
            if (status.check_fail) begin
               reason_in = REASON_MINOR;
               state_in = S_REJECT;
            end else if (status.kinds_bad) begin
               reason_in = REASON_KINDS;
               state_in = S_REJECT;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_REJECT: begin
            if (status.out_free) begin
               cmd.reject_put = 1'b1;
               cmd.clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT_RD: begin
            cmd.emit_start = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_put = 1'b1;
               if (status.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      reason_ff <= reason_in;
   end

endmodule

FILE: hdl/gsfe_dpath.sv
// Datapath with sample store, allele counters, scan, filter multiplier and output register.
`timescale 1ns / 1ps

module gsfe_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  gsfe_pkg::cmd_type             cmd,
   output gsfe_pkg::status_type          status,
   input  gsfe_pkg::cfg_type             cfg,
   input  logic [gsfe_pkg::CODE_W-1:0]   genotype_code,
   gsfe_rsp_if.source                    rsp_if
);
   import gsfe_pkg::*;

   logic [CODE_W-1:0]   store_mem [MAX_SAMPLES];
   logic [CODE_W-1:0]   rd_code_ff;

   logic [ALLELE_W-1:0] allele_ff [NUM_BINS];
   logic [ALLELE_W-1:0] allele_in [NUM_BINS];
   logic [COUNT_W-1:0]  het_ff;
   logic [COUNT_W-1:0]  het_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                overflow_ff;
   logic                overflow_in;
   logic [COUNT_W-1:0]  k_ff;
   logic [COUNT_W-1:0]  k_in;
   logic [COUNT_W-1:0]  k_next;

   logic [BIN_W-1:0]    idx_ff;
   logic [BIN_W-1:0]    idx_in;
   logic [BIN_W-1:0]    best_ff;
   logic [BIN_W-1:0]    best_in;
   logic [BIN_W-1:0]    sec_ff;
   logic [BIN_W-1:0]    sec_in;
   logic [ALLELE_W-1:0] best_c_ff;
   logic [ALLELE_W-1:0] best_c_in;
   logic [ALLELE_W-1:0] sec_c_ff;
   logic [ALLELE_W-1:0] sec_c_in;
   logic [BIN_W-1:0]    kinds_ff;
   logic [BIN_W-1:0]    kinds_in;
   logic [ALLELE_W-1:0] scan_c;

   logic                full;
   logic [BIN_W-1:0]    sa;
   logic [BIN_W-1:0]    sb;

   logic [CFG_W-1:0]    mul_a;
   logic [ALLELE_W-1:0] mul_b;
   logic [PROD_W-1:0]   prod;
   logic [ALLELE_W-1:0] lhs_cnt;
   logic [PROD_W-1:0]   lhs;

   logic                out_free;
   logic                valid_ff;
   logic                valid_in;
   logic [VALUE_W-1:0]  first_ff;
   logic [VALUE_W-1:0]  second_ff;
   logic                pass_ff;
   logic [REASON_W-1:0] reason_ff;
   logic                last_ff;
   logic [2*VALUE_W-1:0] enc;

   // Haplotype pair for one stored token, given the chosen best and second bins.
   function automatic logic [2*VALUE_W-1:0] encode(input logic [CODE_W-1:0] code,
                                                   input logic [BIN_W-1:0] best,
                                                   input logic [BIN_W-1:0] sec);
      logic [2*VALUE_W-1:0] pair;
      pair = {VAL_BEST, VAL_SECOND};
      case (code) inside
         CODE_A, CODE_C, CODE_G, CODE_T: begin
            if (sym_a(code) == best) begin
               pair = {VAL_BEST, VAL_BEST};
            end else if (sym_a(code) == sec) begin
               pair = {VAL_SECOND, VAL_SECOND};
            end
         end
         CODE_N: begin
            if (best != BIN_UNK && sec != BIN_UNK) begin
               pair = {VAL_MISSING, VAL_MISSING};
            end
         end
         CODE_DASH, CODE_LOWER_N: begin
            pair = {VAL_MISSING, VAL_MISSING};
         end
         default: begin
            pair = {VAL_BEST, VAL_SECOND};
         end
      endcase
      return pair;
   endfunction

   assign full = (count_ff == COUNT_W'(MAX_SAMPLES));
   assign sa = sym_a(genotype_code);
   assign sb = sym_b(genotype_code);
   assign k_next = k_ff + COUNT_W'(1);

   always_comb begin
      for (int b = 0; b < NUM_BINS; b++) begin
         allele_in[b] = allele_ff[b];
         if (cmd.clear) begin
            allele_in[b] = '0;
         end else if (cmd.accept && !full) begin
            allele_in[b] = allele_ff[b] + ALLELE_W'(sa == BIN_W'(b))
                           + ALLELE_W'(sb == BIN_W'(b));
         end
      end
      het_in = het_ff;
      count_in = count_ff;
      overflow_in = overflow_ff;
      if (cmd.clear) begin
         het_in = '0;
         count_in = '0;
         overflow_in = 1'b0;
      end else if (cmd.accept) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + COUNT_W'(1);
            het_in = het_ff + COUNT_W'(sa != sb);
         end
      end
      k_in = k_ff;
      if (cmd.emit_start) begin
         k_in = '0;
      end else if (cmd.emit_put) begin
         k_in = k_next;
      end
   end

   // Allele scan, one symbol bin per cycle in ascending order.
   assign scan_c = allele_ff[idx_ff];

   always_comb begin
      idx_in = idx_ff;
      best_in = best_ff;
      sec_in = sec_ff;
      best_c_in = best_c_ff;
      sec_c_in = sec_c_ff;
      kinds_in = kinds_ff;
      if (cmd.scan_init) begin
         idx_in = BIN_UNK;
         best_in = BIN_NONE;
         sec_in = BIN_NONE;
         best_c_in = '0;
         sec_c_in = '0;
         kinds_in = '0;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + BIN_W'(1);
         if (scan_c != '0) begin
            kinds_in = kinds_ff + BIN_W'(1);
            if (scan_c > best_c_ff) begin
               sec_in = best_ff;
               sec_c_in = best_c_ff;
               best_in = idx_ff;
               best_c_in = scan_c;
            end else if (scan_c >= sec_c_ff) begin
               sec_in = idx_ff;
               sec_c_in = scan_c;
            end
         end
      end
   end

   // Cross-multiplied threshold test, one filter per cycle on a shared multiplier.
   always_comb begin
      unique case (cmd.chk)
         CHK_MISS: begin
            mul_a = cfg.missing_limit;
            mul_b = {count_ff, 1'b0};
            lhs_cnt = allele_ff[BIN_MISS];
         end
         CHK_HET: begin
            mul_a = cfg.het_limit;
            mul_b = ALLELE_W'(count_ff);
            lhs_cnt = ALLELE_W'(het_ff);
         end
         default: begin
            mul_a = cfg.minor_floor;
            mul_b = {count_ff, 1'b0};
            lhs_cnt = sec_c_ff;
         end
      endcase
   end

   assign prod = mul_a * mul_b;
   assign lhs = PROD_W'({lhs_cnt, FRAC_W'(0)});

   assign status.check_fail = (cmd.chk == CHK_MINOR) ? (lhs < prod) : (lhs > prod);
   assign status.overflow = overflow_ff;
   assign status.scan_done = (idx_ff == BIN_T);
   assign status.kinds_bad = (kinds_ff != BIN_W'(2));
   assign status.out_free = out_free;
   assign status.emit_last = (k_next == count_ff);

   assign out_free = !valid_ff || rsp_if.ready;
   assign enc = encode(rd_code_ff, best_ff, sec_ff);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit_put || cmd.reject_put) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !full) begin
         store_mem[count_ff[IDX_W-1:0]] <= genotype_code;
      end
      if (cmd.emit_start) begin
         rd_code_ff <= store_mem[IDX_W'(0)];
      end else if (cmd.emit_put) begin
         rd_code_ff <= store_mem[k_next[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BINS; b++) begin
            allele_ff[b] <= '0;
         end
         het_ff <= '0;
         count_ff <= '0;
         overflow_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         allele_ff <= allele_in;
         het_ff <= het_in;
         count_ff <= count_in;
         overflow_ff <= overflow_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      idx_ff <= idx_in;
      best_ff <= best_in;
      sec_ff <= sec_in;
      best_c_ff <= best_c_in;
      sec_c_ff <= sec_c_in;
      kinds_ff <= kinds_in;
      if (cmd.emit_put) begin
         first_ff <= enc[2*VALUE_W-1:VALUE_W];
         second_ff <= enc[VALUE_W-1:0];
         pass_ff <= 1'b1;
         reason_ff <= REASON_NONE;
         last_ff <= status.emit_last;
      end else if (cmd.reject_put) begin
         first_ff <= VAL_BEST;
         second_ff <= VAL_BEST;
         pass_ff <= 1'b0;
         reason_ff <= cmd.reason;
         last_ff <= 1'b1;
      end
   end

   assign rsp_if.valid = valid_ff;
   assign rsp_if.first_value = first_ff;
   assign rsp_if.second_value = second_ff;
   assign rsp_if.site_pass = pass_ff;
   assign rsp_if.reject_reason = reason_ff;
   assign rsp_if.last_result = last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_SAMPLES))
      else $error("sample count beyond store depth");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> full)
      else $error("overflow flagged with store not full");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_put || cmd.reject_put) |-> out_free)
      else $error("output register loaded while a result is held");
`endif

endmodule

FILE: hdl/genotype_site_filter_encoder.sv
// Top level of the genotype site filter encoder.
`timescale 1ns / 1ps
//
//   Channel  Direction  Carries
//   req_if   in         genotype_code, last_sample (one request per sample token)
//   rsp_if   out        first_value, second_value, site_pass, reject_reason, last_result
//   csr_if   in         index, data (threshold register write)
//
// Each token is written to the sample store at its own address.
// After the last token of a site of n samples: an allele scan on the count registers,
// the filter checks in turn on one shared 17x8 multiplier, then either one reject
// result or a store read and n results at one per cycle from the output register.
// Reset is synchronous and active high; it restores the thresholds and clears the counters.
// req_if.ready is low from the last token until the site's final result is loaded;
// a low rsp_if.ready stalls the result pass.

module genotype_site_filter_encoder (
   input logic        clock,
   input logic        reset,
   gsfe_req_if.sink   req_if,
   gsfe_rsp_if.source rsp_if,
   gsfe_csr_if.sink   csr_if
);
   import gsfe_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   gsfe_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   gsfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_sample),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gsfe_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cfg           (cfg),
      .genotype_code (req_if.genotype_code),
      .rsp_if        (rsp_if)
   );

endmodule

FILE: tb/genotype_site_filter_encoder_tb.sv
// Self-checking testbench for the genotype site filter encoder with predictor and random stalls.
`timescale 1ns / 1ps

module genotype_site_filter_encoder_tb;
   import gsfe_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 78;
   localparam int PHASES        = 6;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 26;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [CODE_W-1:0]    CODE_UNK_D = 4'd13;
   localparam logic [CODE_W-1:0]    CODE_UNK_E = 4'd14;
   localparam logic [CODE_W-1:0]    CODE_UNK_F = 4'd15;

   typedef longint unsigned wide_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  first_value;
      logic [VALUE_W-1:0]  second_value;
      logic                site_pass;
      logic [REASON_W-1:0] reject_reason;
      logic                last_result;
   } site_result_type;

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic                last;
      logic                typed;
      logic [REASON_W-1:0] reason;
   } token_row_type;

   logic clock = 1'b0;
   logic reset;

   gsfe_req_if req_if();
   gsfe_rsp_if rsp_if();
   gsfe_csr_if csr_if();

   genotype_site_filter_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #2 clock = ~clock;

   cfg_type          thresholds;
   logic [CODE_W-1:0] token_store [MAX_SAMPLES];
   logic [7:0]       allele_tally [NUM_BINS];
   logic [6:0]       het_tally;
   logic [6:0]       site_samples;
   logic             site_overflow;
   site_result_type  expected_results [$];

   int mismatch_count = 0;
   int results_seen   = 0;
   int tokens_sent    = 0;
   int sites_sent     = 0;
   int sites_passed   = 0;
   int cycle_count    = 0;
   int rsp_stall      = 0;
   bit rsp_burst      = 1'b0;
   bit req_burst      = 1'b0;

   token_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CODE_A,       1'b1, 1'b1, REASON_MINOR},
      '{CODE_N,       1'b1, 1'b1, REASON_MISSING},
      '{CODE_M,       1'b1, 1'b1, REASON_HET},
      '{CODE_DASH,    1'b1, 1'b1, REASON_MISSING},
      '{CODE_A,       1'b0, 1'b0, REASON_NONE},
      '{CODE_C,       1'b1, 1'b0, REASON_NONE},
      '{CODE_A,       1'b0, 1'b0, REASON_NONE},
      '{CODE_M,       1'b0, 1'b0, REASON_NONE},
      '{CODE_C,       1'b0, 1'b0, REASON_NONE},
      '{CODE_C,       1'b1, 1'b0, REASON_NONE},
      '{CODE_LOWER_N, 1'b0, 1'b0, REASON_NONE},
      '{CODE_LOWER_N, 1'b0, 1'b0, REASON_NONE},
      '{CODE_A,       1'b0, 1'b0, REASON_NONE},
      '{CODE_N,       1'b1, 1'b0, REASON_NONE},
      '{CODE_UNK_D,   1'b0, 1'b0, REASON_NONE},
      '{CODE_UNK_E,   1'b0, 1'b0, REASON_NONE},
      '{CODE_UNK_F,   1'b0, 1'b0, REASON_NONE},
      '{CODE_C,       1'b1, 1'b0, REASON_NONE},
      '{CODE_G,       1'b0, 1'b0, REASON_NONE},
      '{CODE_K,       1'b0, 1'b0, REASON_NONE},
      '{CODE_T,       1'b0, 1'b0, REASON_NONE},
      '{CODE_S,       1'b0, 1'b0, REASON_NONE},
      '{CODE_Y,       1'b0, 1'b0, REASON_NONE},
      '{CODE_W_HET,   1'b1, 1'b0, REASON_NONE},
      '{CODE_G,       1'b0, 1'b0, REASON_NONE},
      '{CODE_T,       1'b1, 1'b0, REASON_NONE}
   };

   function automatic void split_code(input logic [CODE_W-1:0] code,
                                      output logic [BIN_W-1:0] hap_a,
                                      output logic [BIN_W-1:0] hap_b);
      case (code)
         CODE_A:            {hap_a, hap_b} = {BIN_A, BIN_A};
         CODE_C:            {hap_a, hap_b} = {BIN_C, BIN_C};
         CODE_G:            {hap_a, hap_b} = {BIN_G, BIN_G};
         CODE_T:            {hap_a, hap_b} = {BIN_T, BIN_T};
         CODE_M:            {hap_a, hap_b} = {BIN_A, BIN_C};
         CODE_R:            {hap_a, hap_b} = {BIN_A, BIN_G};
         CODE_W_HET:        {hap_a, hap_b} = {BIN_A, BIN_T};
         CODE_S:            {hap_a, hap_b} = {BIN_C, BIN_G};
         CODE_Y:            {hap_a, hap_b} = {BIN_C, BIN_T};
         CODE_K:            {hap_a, hap_b} = {BIN_G, BIN_T};
         CODE_N, CODE_DASH: {hap_a, hap_b} = {BIN_MISS, BIN_MISS};
         default:           {hap_a, hap_b} = {BIN_UNK, BIN_UNK};
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] het_between(input logic [CODE_W-1:0] x,
                                                     input logic [CODE_W-1:0] y);
      logic [CODE_W-1:0] lo;
      logic [CODE_W-1:0] hi;
      logic [CODE_W-1:0] het;
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      case ({lo, hi})
         {CODE_A, CODE_C}: het = CODE_M;
         {CODE_A, CODE_G}: het = CODE_R;
         {CODE_A, CODE_T}: het = CODE_W_HET;
         {CODE_C, CODE_G}: het = CODE_S;
         {CODE_C, CODE_T}: het = CODE_Y;
         default:          het = CODE_K;
      endcase
      return het;
   endfunction

   task automatic clear_site_tally();
      for (int b = 0; b < NUM_BINS; b++) allele_tally[b] = '0;
      het_tally     = '0;
      site_samples  = '0;
      site_overflow = 1'b0;
   endtask

   task automatic queue_expected(input site_result_type item);
      expected_results = {expected_results, item};
   endtask

   task automatic expect_reject(input logic [REASON_W-1:0] reason);
      queue_expected('{VAL_BEST, VAL_BEST, 1'b0, reason, 1'b1});
   endtask

   task automatic close_site(input bit push);
      logic [BIN_W-1:0]    best;
      logic [BIN_W-1:0]    runner;
      logic [BIN_W-1:0]    bin;
      logic [REASON_W-1:0] reason;
      logic [CODE_W-1:0]   code;
      logic [VALUE_W-1:0]  v0;
      logic [VALUE_W-1:0]  v1;
      int                  best_n;
      int                  runner_n;
      int                  kinds;
      int                  tally;
      wide_type            n;
      n        = wide_type'(site_samples);
      best     = BIN_NONE;
      runner   = BIN_NONE;
      best_n   = 0;
      runner_n = 0;
      kinds    = 0;
      for (int b = 0; b < 5; b++) begin
         tally = int'(allele_tally[b]);
         if (tally != 0) begin
            if (tally > best_n) begin
               runner_n = best_n;
               runner   = best;
               best_n   = tally;
               best     = b[BIN_W-1:0];
            end else if (tally >= runner_n) begin
               runner_n = tally;
               runner   = b[BIN_W-1:0];
            end
            kinds++;
         end
      end
      if (site_overflow)
         reason = REASON_OVERFLOW;
      else if (wide_type'(allele_tally[BIN_MISS]) * 65536 >
               wide_type'(thresholds.missing_limit) * 2 * n)
         reason = REASON_MISSING;
      else if (wide_type'(het_tally) * 65536 > wide_type'(thresholds.het_limit) * n)
         reason = REASON_HET;
      else if (wide_type'(runner_n) * 65536 <
               wide_type'(thresholds.minor_floor) * 2 * n)
         reason = REASON_MINOR;
      else if (kinds != 2)
         reason = REASON_KINDS;
      else
         reason = REASON_NONE;
      if (!push) return;
      if (reason != REASON_NONE) begin
         expect_reject(reason);
      end else begin
         sites_passed++;
         for (int k = 0; k < site_samples; k++) begin
            code = token_store[k[IDX_W-1:0]];
            v0   = VAL_BEST;
            v1   = VAL_SECOND;
            if (code <= CODE_T) begin
               bin = code[BIN_W-1:0] + 3'd1;
               if (bin == best) begin
                  v0 = VAL_BEST;
                  v1 = VAL_BEST;
               end else if (bin == runner) begin
                  v0 = VAL_SECOND;
                  v1 = VAL_SECOND;
               end
            end else if (code == CODE_N) begin
               if (best != BIN_UNK && runner != BIN_UNK) begin
                  v0 = VAL_MISSING;
                  v1 = VAL_MISSING;
               end
            end else if (code == CODE_DASH || code == CODE_LOWER_N) begin
               v0 = VAL_MISSING;
               v1 = VAL_MISSING;
            end
            queue_expected('{v0, v1, 1'b1, REASON_NONE, (k + 1 == site_samples)});
         end
      end
   endtask

   task automatic account_token(input logic [CODE_W-1:0] code, input bit last, input bit push);
      logic [BIN_W-1:0] hap_a;
      logic [BIN_W-1:0] hap_b;
      if (site_samples < MAX_SAMPLES) begin
         token_store[site_samples[IDX_W-1:0]] = code;
         site_samples++;
         split_code(code, hap_a, hap_b);
         allele_tally[hap_a]++;
         allele_tally[hap_b]++;
         if (hap_a != hap_b) het_tally++;
      end else begin
         site_overflow = 1'b1;
      end
      if (last) begin
         close_site(push);
         clear_site_tally();
         sites_sent++;
      end
   endtask

   // Valid stays high between back-to-back requests; it is lowered for a random gap when no burst runs.
   task automatic send_token(input logic [CODE_W-1:0] code, input bit last, input bit push);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) req_burst = ~req_burst;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.genotype_code <= code;
      req_if.last_sample   <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tokens_sent++;
      account_token(code, last, push);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (index)
         CSR_MISSING_LIMIT: thresholds.missing_limit = value;
         CSR_HET_LIMIT:     thresholds.het_limit     = value;
         CSR_MINOR_FLOOR:   thresholds.minor_floor   = value;
         default:           ;
      endcase
   endtask

   // Mostly two-allele sites with random content and some fully random sites.
   // Long sites are cut to the requests left in the phase.
   task automatic run_site(input int room);
      int                site_len;
      int                pick;
      bit                mixed;
      logic [CODE_W-1:0] major;
      logic [CODE_W-1:0] minor;
      logic [CODE_W-1:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         site_len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 3);
      else if (pick < 10)
         site_len = $urandom_range(11, MAX_SAMPLES);
      else
         site_len = $urandom_range(1, 10);
      if (site_len > room) site_len = room;
      mixed = ($urandom_range(0, 9) < 3);
      major = CODE_W'($urandom_range(0, 3));
      minor = CODE_W'((major + $urandom_range(1, 3)) % 4);
      for (int k = 0; k < site_len; k++) begin
         pick = $urandom_range(0, 99);
         if (mixed || pick >= 97) code = CODE_W'($urandom_range(0, 15));
         else if (pick < 45)      code = major;
         else if (pick < 75)      code = minor;
         else if (pick < 88)      code = het_between(major, minor);
         else if (pick < 92)      code = CODE_N;
         else if (pick < 95)      code = CODE_DASH;
         else                     code = CODE_LOWER_N;
         send_token(code, k == site_len - 1, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("genotype_site_filter_encoder verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      site_result_type got;
      site_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.first_value, rsp_if.second_value, rsp_if.site_pass,
                    rsp_if.reject_reason, rsp_if.last_result};
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Unexpected result at cycle %0d: %p", cycle_count, got);
            end else begin
               want = expected_results.pop_front();
               if (got.first_value !== want.first_value ||
                   got.second_value !== want.second_value ||
                   got.site_pass !== want.site_pass ||
                   got.reject_reason !== want.reject_reason ||
                   got.last_result !== want.last_result) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("Mismatch at cycle %0d: expected %p, got %p",
                              cycle_count, want, got);
               end
            end
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0) rsp_burst = ~rsp_burst;
         end
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      int               phase_start;
      logic [CFG_W-1:0] missing_value;
      logic [CFG_W-1:0] het_value;
      logic [CFG_W-1:0] minor_value;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.genotype_code <= CODE_A;
      req_if.last_sample   <= 1'b0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= CSR_MISSING_LIMIT;
      csr_if.data          <= '0;
      thresholds = '{MISSING_LIMIT_RESET, HET_LIMIT_RESET, MINOR_FLOOR_RESET};
      clear_site_tally();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_token(directed_rows[r].code, directed_rows[r].last, !directed_rows[r].typed);
         if (directed_rows[r].typed) expect_reject(directed_rows[r].reason);
      end
      // A full site at the sample limit, then a site one request past it.
      for (int k = 0; k < MAX_SAMPLES; k++)
         send_token(k[0] ? CODE_C : CODE_A, k == MAX_SAMPLES - 1, 1'b1);
      for (int k = 0; k <= MAX_SAMPLES; k++)
         send_token(CODE_W'($urandom_range(0, 15)), k == MAX_SAMPLES, 1'b0);
      expect_reject(REASON_OVERFLOW);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: {missing_value, het_value, minor_value} = {17'd0, 17'd0, 17'd0};
            1: {missing_value, het_value, minor_value} = {17'd65536, 17'd65536, 17'd0};
            2: {missing_value, het_value, minor_value} = {17'h1FFFF, 17'h1FFFF, 17'h1FFFF};
            3: {missing_value, het_value, minor_value} =
                  {MISSING_LIMIT_RESET, HET_LIMIT_RESET, MINOR_FLOOR_RESET};
            default: begin
               missing_value = CFG_W'($urandom_range(8192, 65536));
               het_value     = CFG_W'($urandom_range(16384, 65536));
               minor_value   = CFG_W'($urandom_range(0, 4096));
            end
         endcase
         write_reg(CSR_MISSING_LIMIT, missing_value);
         write_reg(CSR_HET_LIMIT, het_value);
         write_reg(CSR_MINOR_FLOOR, minor_value);
         if (p == 3) write_reg(CSR_UNUSED, CFG_W'($urandom_range(0, 131071)));
         csr_if.valid <= 1'b0;
         phase_start = tokens_sent;
         while (tokens_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 7) == 0) drain_results();
            run_site(RANDOM_ITEMS / PHASES - (tokens_sent - phase_start));
         end
         drain_results();
      end

      $display("Covered %0d sites from %0d requests and checked %0d results;", sites_sent,
               tokens_sent, results_seen);
      $display("%0d sites passed the filters across %0d threshold settings.", sites_passed,
               PHASES + 1);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("genotype_site_filter_encoder verification clean");
      end else begin
         $display("genotype_site_filter_encoder verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/gsfe_pkg.sv
hdl/gsfe_req_if.sv
hdl/gsfe_rsp_if.sv
hdl/gsfe_csr_if.sv
hdl/gsfe_regs.sv
hdl/gsfe_ctrl.sv
hdl/gsfe_dpath.sv
hdl/genotype_site_filter_encoder.sv
tb/genotype_site_filter_encoder_tb.sv
